[rtl/md5sh_pkg.sv]
// shared types, constants and round functions for the md5 stream hasher
`timescale 1ns / 1ps
`default_nettype none
package md5sh_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        final_word;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_byte;      // write byte into buffer at fill, count it
    logic       wr_pad;       // write pad byte at fill position
    logic       pad_len;      // pad byte at fill comes from the length field
    logic       zero_byte;    // pad byte is zero rather than 0x80
    logic       round_start;  // load working regs from chain
    logic       round_step;   // run one round
    logic       round_done;   // add working regs into chain
    logic       msg_restart;  // reinit chain, fill and length
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } dp_sts_t;

  localparam logic [31:0] ChainInit [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenFieldAt = 6'd56;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word index for a round
  function automatic logic [3:0] word_sel(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] phase,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

[rtl/md5_stream_hasher.sv]
// md5 stream hasher top level: controller plus datapath
`timescale 1ns / 1ps
// at most one byte per transaction; a byte not completing a block or ending the message keeps it idle
// a block completion primes the first word read, runs the rounds, then updates the chain:
// the single shared round unit runs one md5 round per cycle from the block buffer memory
// message end adds pad writes (one byte per cycle) and one or two compressions,
// then four result transactions; reset restores the standard chaining words
// reset is synchronous active low; the block buffer is not cleared
`default_nettype none
module md5_stream_hasher (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire md5sh_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output md5sh_pkg::out_item_t      out_data
);

  md5sh_pkg::dp_cmd_t cmd;
  md5sh_pkg::dp_sts_t sts;
  logic [1:0]  sel;
  logic [31:0] word;

  // sequencing of intake, padding and rounds
  md5sh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_item(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_sel(sel),
    .cmd(cmd), .sts(sts)
  );

  // buffer, counters and the round unit
  md5sh_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .byte_in(in_data.message_byte), .cmd(cmd),
    .rd_word_sel(sel), .rd_word(word), .sts(sts)
  );

  // digest words come straight from the stable chain registers
  assign out_data.digest_word = word;
  assign out_data.word_number = sel;
  assign out_data.final_word  = (sel == 2'd3);

endmodule
`default_nettype wire

[rtl/md5sh_datapath.sv]
// md5 datapath: block buffer memory, length, chaining and round registers
`timescale 1ns / 1ps
`default_nettype none
module md5sh_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        byte_in,
  input  wire md5sh_pkg::dp_cmd_t cmd,
  input  wire logic [1:0]        rd_word_sel,
  output logic [31:0]            rd_word,
  output md5sh_pkg::dp_sts_t     sts
);

  // buffer held as 16 words, one byte lane written per cycle
  logic [31:0] buf_mem [16];
  logic [31:0] wbuf_r;          // registered read of the message word
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  round_r;
  logic [7:0]  wdata;
  logic [3:0]  rd_addr;
  logic [31:0] t_sum, t_rot;
  logic [4:0]  sh;
  logic [5:0]  len_byte_idx;

  // bit offset of the length-field byte for the current pad slot
  assign len_byte_idx = {fill_r[2:0], 3'b000};

  always_comb begin
    if (cmd.wr_byte) begin
      wdata = byte_in;
    end else if (cmd.pad_len) begin
      wdata = len_r[len_byte_idx +: 8];
    end else if (cmd.zero_byte) begin
      wdata = 8'h00;
    end else begin
      wdata = md5sh_pkg::PadMark;
    end
  end

  // read address runs one round ahead; round_start reads round 0
  assign rd_addr = cmd.round_start ? md5sh_pkg::word_sel(6'd0)
                                   : md5sh_pkg::word_sel(6'(round_r + 6'd1));

  always_ff @(posedge clk) begin
    if (cmd.wr_byte || cmd.wr_pad) begin
      buf_mem[fill_r[5:2]][fill_r[1:0]*8 +: 8] <= wdata;
    end
    wbuf_r <= buf_mem[rd_addr];
  end

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    if (cmd.msg_restart) begin
      fill_nxt = '0;
      len_nxt  = '0;
    end else if (cmd.wr_byte || cmd.wr_pad) begin
      fill_nxt = 6'(fill_r + 6'd1);
      if (cmd.wr_byte) len_nxt = len_r + 64'd8;
    end
  end

  assign t_sum = a_r + md5sh_pkg::round_fn(round_r[5:4], b_r, c_r, d_r)
               + wbuf_r + md5sh_pkg::RoundConst[round_r];
  assign sh    = md5sh_pkg::RotAmount[{round_r[5:4], round_r[1:0]}];
  assign t_rot = (t_sum << sh) | (t_sum >> (6'd32 - {1'b0, sh}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      for (int i = 0; i < 4; i++) chain_r[i] <= md5sh_pkg::ChainInit[i];
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      if (cmd.msg_restart) begin
        for (int i = 0; i < 4; i++) chain_r[i] <= md5sh_pkg::ChainInit[i];
      end else if (cmd.round_done) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      round_r <= '0;
    end else if (cmd.round_step) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + t_rot;
      round_r <= 6'(round_r + 6'd1);
    end
  end

  assign rd_word   = chain_r[rd_word_sel];
  assign sts.fill  = fill_r;
  assign sts.round = round_r;

endmodule
`default_nettype wire

[rtl/md5sh_ctrl.sv]
// md5 controller: intake, padding sequence, compression and digest output
`timescale 1ns / 1ps
`default_nettype none
module md5sh_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire md5sh_pkg::in_item_t in_item,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_sel,
  output md5sh_pkg::dp_cmd_t      cmd,
  input  wire md5sh_pkg::dp_sts_t sts
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;  // writing pad bytes
  localparam logic [2:0] StPrime = 3'd2;  // first word read in flight
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;     // padding pending after this compression
  logic       mark_r, mark_nxt;   // 0x80 already written
  logic       spill_r, spill_nxt; // marker landed in the length field slots
  logic [1:0] sel_r, sel_nxt;
  logic       acc;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != StIdle);
  assign out_valid = (state_r == StOut);
  assign out_sel  = sel_r;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    spill_nxt = spill_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    case (state_r)
      StIdle: begin
        if (acc) begin
          cmd.wr_byte = in_item.byte_present;
          fin_nxt     = in_item.end_of_message;
          mark_nxt    = 1'b0;
          if (in_item.byte_present && sts.fill == 6'd63) begin
            state_nxt = StPrime;
          end else if (in_item.end_of_message) begin
            state_nxt = StPad;
          end
        end
      end
      StPad: begin
        cmd.wr_pad    = 1'b1;
        cmd.zero_byte = mark_r;
        mark_nxt      = 1'b1;
        // length field only once the marker is in and the block has room
        cmd.pad_len   = mark_r && fin_r && !spill_r && (sts.fill >= md5sh_pkg::LenFieldAt);
        if (!mark_r && (sts.fill >= md5sh_pkg::LenFieldAt)) spill_nxt = 1'b1;
        if (sts.fill == 6'd63) begin
          // block full: length written only if this is its last slot
          fin_nxt   = !cmd.pad_len ? fin_r : 1'b0;
          spill_nxt = 1'b0;
          state_nxt = StPrime;
        end
      end
      StPrime: begin
        cmd.round_start = 1'b1;
        state_nxt = StRound;
      end
      StRound: begin
        cmd.round_step = 1'b1;
        if (sts.round == 6'd63) state_nxt = StAdd;
      end
      StAdd: begin
        cmd.round_done = 1'b1;
        if (fin_r) begin
          state_nxt = StPad;
        end else if (mark_r) begin
          sel_nxt   = '0;
          state_nxt = StOut;
        end else begin
          state_nxt = StIdle;
        end
      end
      StOut: begin
        if (!out_stall) begin
          sel_nxt = 2'(sel_r + 2'd1);
          if (sel_r == 2'd3) begin
            cmd.msg_restart = 1'b1;
            mark_nxt  = 1'b0;
            state_nxt = StIdle;
          end
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      spill_r <= 1'b0;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      spill_r <= spill_nxt;
      sel_r   <= sel_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> !acc) else $error("item taken while busy");
  a_round_follows_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StPrime) |=> (state_r == StRound)) else $error("prime not followed");
  a_out_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == StAdd && sel_r == 2'd0))
    else $error("bad digest start");

endmodule
`default_nettype wire
